// File: hdl/sem_pkg.sv
// Shared types and constants for the RGB Sobel edge magnitude block.
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 24;
    localparam int ROOT_STEPS = 11;

    // Configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // Sobel kernels, row order
    localparam logic signed [2:0] KERN_GX [9] = '{-3'sd1, 3'sd0, 3'sd1,
                                                   -3'sd2, 3'sd0, 3'sd2,
                                                   -3'sd1, 3'sd0, 3'sd1};
    localparam logic signed [2:0] KERN_GY [9] = '{-3'sd1, -3'sd2, -3'sd1,
                                                   3'sd0, 3'sd0, 3'sd0,
                                                   3'sd1, 3'sd2, 3'sd1};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_SQUARE,
        ST_ROOT,
        ST_OUT
    } sem_state_t;

endpackage
`default_nettype wire

// File: hdl/sem_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: hdl/sobel_edge_magnitude_rgb.sv
// Top level: streaming 3x3 Sobel edge magnitude on RGB pixels.
//
// Pixels come in on the input channel (in_valid/in_ready) in raster order,
// blue, green and red at 8 bits each. Each accepted beat may cause up to
// four result beats on the output channel (out_valid/out_ready), each with
// per-channel floor(sqrt(gx^2+gy^2)) saturated at 255, the pixel's row and
// column, last_of_run on the final result of that input and frame_done on
// the result of the frame's last pixel. Pixels outside the frame count as
// zero. A pixel's result leaves once its lower-right neighbour is in, or
// earlier at the right or bottom edge.
// The two previous rows live in two line-buffer RAMs (one read, one write
// port, registered read): a pixel is read at accept and the rows are
// shifted and written back in the next cycle.
// Flow: one item is worked at a time. Each result passes the calc and
// square states, then the 11-step square-root unit (one result bit per
// cycle, three channels side by side), then waits in the output state.
// An input with no result frees the block after its read state.
// When the receiver stalls the result beat holds and no new pixel is taken.
// Reset clears counters, window and control; the line buffers need no clear.
// Configuration (cfg_we/cfg_index/cfg_data) is for the user to write only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  blue_in,
    input  wire logic [7:0]  green_in,
    input  wire logic [7:0]  red_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       blue_edge,
    output logic [7:0]       green_edge,
    output logic [7:0]       red_edge,
    output logic [11:0]      out_row,
    output logic [9:0]       out_column,
    output logic             last_of_run,
    output logic             frame_done
);

    sem_state_t state_reg, state_next;

    logic [10:0] image_width_reg;
    logic [12:0] image_height_reg;

    logic [ADDR_W-1:0] col_reg;
    logic [11:0]       row_reg;
    logic [PIX_W-1:0]  win_reg [6];

    // latched item
    logic [ADDR_W-1:0] c_reg;
    logic [11:0]       r_reg;
    logic [10:0]       wid_reg;
    logic [12:0]       hgt_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [PIX_W-1:0]  grid_reg [3][3];
    logic [3:0]        pend_reg;

    // current emission
    logic              ysel_reg, xsel_reg, last_reg, done_reg;
    logic signed [11:0] gx_reg [3];
    logic signed [11:0] gy_reg [3];
    logic [21:0]       sq_reg   [3];
    logic [11:0]       rem_reg  [3];
    logic [10:0]       root_reg [3];
    logic [3:0]        step_reg;

    logic [10:0] wid_clamp;
    logic [12:0] hgt_clamp;
    logic [PIX_W-1:0] row2_rd, row1_rd;
    logic        last_col, last_row, c_nz, r_nz;
    logic [3:0]  emit_mask;
    logic [1:0]  pick;
    logic [3:0]  pend_after;
    logic signed [11:0] gx_c [3];
    logic signed [11:0] gy_c [3];
    logic        accept;

    assign accept = in_valid && in_ready;

    // clamp of the geometry registers
    always_comb
    begin
        if (image_width_reg == 11'd0)
            wid_clamp = 11'd1;
        else if (image_width_reg > 11'(MAX_WIDTH))
            wid_clamp = 11'(MAX_WIDTH);
        else
            wid_clamp = image_width_reg;
        if (image_height_reg == 13'd0)
            hgt_clamp = 13'd1;
        else if (image_height_reg > 13'(MAX_HEIGHT))
            hgt_clamp = 13'(MAX_HEIGHT);
        else
            hgt_clamp = image_height_reg;
    end

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_two (
        .clk   (clk),
        .we    (state_reg == ST_READ),
        .waddr (c_reg),
        .wdata (row1_rd),
        .raddr (col_reg),
        .rdata (row2_rd)
    );

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_one (
        .clk   (clk),
        .we    (state_reg == ST_READ),
        .waddr (c_reg),
        .wdata (pix_reg),
        .raddr (col_reg),
        .rdata (row1_rd)
    );

    assign last_col = {1'b0, c_reg} >= (wid_reg - 11'd1);
    assign last_row = {1'b0, r_reg} >= (hgt_reg - 13'd1);
    assign c_nz     = c_reg != '0;
    assign r_nz     = r_reg != '0;
    // order: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
    assign emit_mask = {last_row && last_col, last_row && c_nz,
                        r_nz && last_col, r_nz && c_nz};

    always_comb
    begin
        priority if (pend_reg[0]) pick = 2'd0;
        else if (pend_reg[1])     pick = 2'd1;
        else if (pend_reg[2])     pick = 2'd2;
        else                      pick = 2'd3;
        pend_after       = pend_reg;
        pend_after[pick] = 1'b0;
    end

    // 3x3 convolution for the picked emission, zero outside the frame
    always_comb
    begin
        logic [1:0]         yi, xi;
        logic signed [14:0] ar, ac;
        logic [7:0]         v;
        for (int ch = 0; ch < 3; ch++)
        begin
            gx_c[ch] = '0;
            gy_c[ch] = '0;
            for (int k = 0; k < 9; k++)
            begin
                yi = 2'(k / 3) + {1'b0, pick[1]} + 2'd0;
                xi = 2'(k % 3) + {1'b0, pick[0]} + 2'd0;
                ar = $signed({3'b0, r_reg}) - 15'sd2 + $signed({13'b0, yi});
                ac = $signed({5'b0, c_reg}) - 15'sd2 + $signed({13'b0, xi});
                v  = '0;
                if (yi != 2'd3 && xi != 2'd3 && ar >= 15'sd0 && ac >= 15'sd0 &&
                    ar <= $signed({2'b0, hgt_reg}) - 15'sd1 &&
                    ac <= $signed({4'b0, wid_reg}) - 15'sd1)
                    v = grid_reg[yi][xi][8*ch +: 8];
                gx_c[ch] = gx_c[ch] + $signed({4'b0, v}) * 12'(KERN_GX[k]);
                gy_c[ch] = gy_c[ch] + $signed({4'b0, v}) * 12'(KERN_GY[k]);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_READ;
            ST_READ:   state_next = (emit_mask != '0) ? ST_CALC : ST_IDLE;
            ST_CALC:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_ROOT;
            ST_ROOT:   if (step_reg == 4'(ROOT_STEPS - 1)) state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = (pend_reg != '0) ? ST_CALC : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready  = 1'b1;
            ST_OUT:  out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            image_width_reg  <= 11'd640;
            image_height_reg <= 13'd480;
            col_reg          <= '0;
            row_reg          <= '0;
            pend_reg         <= '0;
            step_reg         <= '0;
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_IMAGE_WIDTH)
                    image_width_reg <= cfg_data[10:0];
                else
                    image_height_reg <= cfg_data;
            end
            if (state_reg == ST_READ)
            begin
                pend_reg <= emit_mask;
                for (int i = 0; i < 3; i++) win_reg[3 + i] <= win_reg[i];
                win_reg[0] <= row2_rd;
                win_reg[1] <= row1_rd;
                win_reg[2] <= pix_reg;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? 12'd0 : r_reg + 12'd1;
                end
                else
                begin
                    col_reg <= c_reg + 1'b1;
                end
            end
            if (state_reg == ST_CALC)
                pend_reg <= pend_after;
            if (state_reg == ST_SQUARE)
                step_reg <= '0;
            else if (state_reg == ST_ROOT)
                step_reg <= step_reg + 4'd1;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        logic [12:0] rem_sh, trial;
        if (accept)
        begin
            pix_reg <= {red_in, green_in, blue_in};
            c_reg   <= col_reg;
            r_reg   <= row_reg;
            wid_reg <= wid_clamp;
            hgt_reg <= hgt_clamp;
        end
        if (state_reg == ST_READ)
        begin
            for (int i = 0; i < 3; i++)
            begin
                grid_reg[i][0] <= win_reg[3 + i];
                grid_reg[i][1] <= win_reg[i];
            end
            grid_reg[0][2] <= row2_rd;
            grid_reg[1][2] <= row1_rd;
            grid_reg[2][2] <= pix_reg;
        end
        if (state_reg == ST_CALC)
        begin
            ysel_reg <= pick[1];
            xsel_reg <= pick[0];
            last_reg <= pend_after == '0;
            done_reg <= pick == 2'd3;
            for (int ch = 0; ch < 3; ch++)
            begin
                gx_reg[ch] <= gx_c[ch];
                gy_reg[ch] <= gy_c[ch];
            end
        end
        if (state_reg == ST_SQUARE)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                sq_reg[ch]   <= 22'(gx_reg[ch] * gx_reg[ch]) +
                                22'(gy_reg[ch] * gy_reg[ch]);
                rem_reg[ch]  <= '0;
                root_reg[ch] <= '0;
            end
        end
        if (state_reg == ST_ROOT)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                rem_sh = {rem_reg[ch][10:0], sq_reg[ch][21:20]};
                trial  = {root_reg[ch], 2'b01};
                sq_reg[ch] <= {sq_reg[ch][19:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg[ch]  <= 12'(rem_sh - trial);
                    root_reg[ch] <= {root_reg[ch][9:0], 1'b1};
                end
                else
                begin
                    rem_reg[ch]  <= rem_sh[11:0];
                    root_reg[ch] <= {root_reg[ch][9:0], 1'b0};
                end
            end
        end
    end

    assign blue_edge   = (root_reg[0] > 11'd255) ? 8'd255 : root_reg[0][7:0];
    assign green_edge  = (root_reg[1] > 11'd255) ? 8'd255 : root_reg[1][7:0];
    assign red_edge    = (root_reg[2] > 11'd255) ? 8'd255 : root_reg[2][7:0];
    assign out_row     = r_reg - 12'd1 + {11'd0, ysel_reg};
    assign out_column  = c_reg - 10'd1 + {9'd0, xsel_reg};
    assign last_of_run = last_reg;
    assign frame_done  = done_reg;

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the streaming RGB Sobel edge magnitude block.
`timescale 1ns / 1ps
`default_nettype none
module testbench
    import sem_pkg::*;
();

    // One result beat as the block presents it
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [11:0] row;
        logic [9:0]  column;
        logic        last;
        logic        done;
    } edge_beat_t;

    // Directed stimulus: optional resize, one pixel, optional typed result
    typedef struct packed {
        logic        resize;
        logic [10:0] wid;
        logic [12:0] hgt;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        typed;
        edge_beat_t  want;
    } pixel_row_t;

    localparam int SETTLE    = 40;      // covers the path from input beat to result plus pipeline
    localparam int CYCLE_CAP = 600000;

    localparam edge_beat_t LONE_PIXEL = '{8'd0, 8'd0, 8'd0, 12'd0, 10'd0, 1'b1, 1'b1};
    localparam edge_beat_t NO_BEAT    = '0;

    localparam pixel_row_t DIRECTED [20] = '{
        // 1x1 frames: every neighbour is padding, so magnitude is zero
        '{1'b1, 11'd1, 13'd1, 8'd255, 8'd255, 8'd255, 1'b1, LONE_PIXEL},
        '{1'b0, 11'd0, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, LONE_PIXEL},
        // zero sizes act as one
        '{1'b1, 11'd0, 13'd0, 8'h55, 8'hAA, 8'h0F, 1'b1, LONE_PIXEL},
        // full 3x3 frame with hard edges
        '{1'b1, 11'd3, 13'd3, 8'd255, 8'd0, 8'd0, 1'b0, NO_BEAT},
        '{1'b0, 11'd0, 13'd0, 8'd0, 8'd255, 8'd0, 1'b0, NO_BEAT},
        '{1'b0, 11'd0, 13'd0, 8'd0, 8'd0, 8'd255, 1'b0, NO_BEAT},
        '{1'b0, 11'd0, 13'd0, 8'd255, 8'd255, 8'd255, 1'b0, NO_BEAT},
        '{1'b0, 11'd0, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, NO_BEAT},
        '{1'b0, 11'd0, 13'd0, 8'd128, 8'd127, 8'd1, 1'b0, NO_BEAT},
        '{1'b0, 11'd0, 13'd0, 8'd255, 8'd255, 8'd255, 1'b0, NO_BEAT},
        '{1'b0, 11'd0, 13'd0, 8'd0, 8'd255, 8'd0, 1'b0, NO_BEAT},
        '{1'b0, 11'd0, 13'd0, 8'd255, 8'd0, 8'd255, 1'b0, NO_BEAT},
        // oversize registers clamp; first row gives nothing
        '{1'b1, 11'd2047, 13'd8191, 8'd1, 8'd2, 8'd3, 1'b0, NO_BEAT},
        '{1'b0, 11'd0, 13'd0, 8'd4, 8'd5, 8'd6, 1'b0, NO_BEAT},
        '{1'b0, 11'd0, 13'd0, 8'd7, 8'd8, 8'd9, 1'b0, NO_BEAT},
        // shrink mid-row: column beyond new width is taken as last column
        '{1'b1, 11'd1, 13'd2, 8'd200, 8'd100, 8'd50, 1'b0, NO_BEAT},
        '{1'b0, 11'd0, 13'd0, 8'd9, 8'd9, 8'd9, 1'b0, NO_BEAT},
        // widest row, single-row frame
        '{1'b1, 11'd1024, 13'd1, 8'd255, 8'd0, 8'd255, 1'b0, NO_BEAT},
        '{1'b0, 11'd0, 13'd0, 8'd1, 8'd1, 8'd1, 1'b0, NO_BEAT},
        '{1'b0, 11'd0, 13'd0, 8'd254, 8'd128, 8'd127, 1'b0, NO_BEAT}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  blue_edge;
    logic [7:0]  green_edge;
    logic [7:0]  red_edge;
    logic [11:0] out_row;
    logic [9:0]  out_column;
    logic        last_of_run;
    logic        frame_done;

    // Predictor state, mirrors the block after each accepted beat
    logic [23:0] line_older [MAX_WIDTH];
    logic [23:0] line_newer [MAX_WIDTH];
    logic [23:0] win_cols [6];
    logic [9:0]  col_pos;
    logic [11:0] row_pos;
    logic [10:0] width_reg;
    logic [12:0] height_reg;

    edge_beat_t  pending_edges [$];
    int          fresh_index;   // queue slot of the first edge of the latest pixel
    int          mismatches;
    int          pixels_sent;
    int          edges_seen;
    int          resizes;
    int          cycle_count;
    logic        calm;       // no idling on either side while set

    sobel_edge_magnitude_rgb u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .blue_in     (blue_in),
        .green_in    (green_in),
        .red_in      (red_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .blue_edge   (blue_edge),
        .green_edge  (green_edge),
        .red_edge    (red_edge),
        .out_row     (out_row),
        .out_column  (out_column),
        .last_of_run (last_of_run),
        .frame_done  (frame_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Floor of the square root, built bit by bit from the top
    function automatic logic [15:0] floor_root(input logic [31:0] v);
        logic [15:0] acc;
        logic [15:0] trial;
        acc = '0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = acc | (16'd1 << b);
            if (32'(trial) * 32'(trial) <= v)
                acc = trial;
        end
        return acc;
    endfunction

    // Gradient magnitude of one pixel in the 4x4 neighbourhood grid.
    // Grid rows are image rows r-2..r+1, columns c-2..c+1.
    function automatic edge_beat_t grade_pixel(input logic [23:0] grid [4][4],
                                               input int cy, input int cx,
                                               input int r, input int c,
                                               input int hgt, input int wid);
        edge_beat_t  beat;
        logic [7:0]  mag [3];
        int          gx;
        int          gy;
        int          ar;
        int          ac;
        int          v;
        logic [15:0] root;
        for (int ch = 0; ch < 3; ch++)
        begin
            gx = 0;
            gy = 0;
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++)
                begin
                    ar = r - 2 + cy + dy;
                    ac = c - 2 + cx + dx;
                    v  = 0;
                    if (ar >= 0 && ar < hgt && ac >= 0 && ac < wid)
                        v = int'(grid[cy + dy][cx + dx][8 * ch +: 8]);
                    // centre row/column weighs double
                    gx += v * dx * ((dy == 0) ? 2 : 1);
                    gy += v * dy * ((dx == 0) ? 2 : 1);
                end
            root    = floor_root(32'(gx * gx + gy * gy));
            mag[ch] = (root > 16'd255) ? 8'd255 : root[7:0];
        end
        beat.blue   = mag[0];
        beat.green  = mag[1];
        beat.red    = mag[2];
        beat.row    = 12'(r - 2 + cy);
        beat.column = 10'(c - 2 + cx);
        beat.last   = 1'b0;
        beat.done   = 1'b0;
        return beat;
    endfunction

    // Advance the predictor by one pixel and queue the edges it releases
    function automatic void absorb_pixel(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r);
        logic [23:0] grid [4][4];
        logic [23:0] pix;
        edge_beat_t  beat;
        int          wid;
        int          hgt;
        int          c;
        int          rw;
        int          slot;
        int          first;
        logic        end_col;
        logic        end_row;
        wid = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        hgt = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT
                                                                  : int'(height_reg));
        pix     = {r, g, b};
        c       = int'(col_pos);
        rw      = int'(row_pos);
        slot    = c % MAX_WIDTH;
        end_col = (c >= wid - 1);
        end_row = (rw >= hgt - 1);
        first   = pending_edges.size();
        fresh_index = first;
        for (int y = 0; y < 4; y++)
            for (int x = 0; x < 4; x++)
                grid[y][x] = '0;
        for (int i = 0; i < 3; i++)
        begin
            grid[i][0] = win_cols[3 + i];
            grid[i][1] = win_cols[i];
        end
        grid[0][2] = line_older[slot];
        grid[1][2] = line_newer[slot];
        grid[2][2] = pix;

        if (rw >= 1 && c >= 1)
            pending_edges.push_back(grade_pixel(grid, 1, 1, rw, c, hgt, wid));
        if (rw >= 1 && end_col)
            pending_edges.push_back(grade_pixel(grid, 1, 2, rw, c, hgt, wid));
        if (end_row && c >= 1)
            pending_edges.push_back(grade_pixel(grid, 2, 1, rw, c, hgt, wid));
        if (end_row && end_col)
        begin
            beat      = grade_pixel(grid, 2, 2, rw, c, hgt, wid);
            beat.done = 1'b1;
            pending_edges.push_back(beat);
        end
        if (pending_edges.size() > first)
            pending_edges[pending_edges.size() - 1].last = 1'b1;

        for (int i = 0; i < 3; i++)
        begin
            win_cols[3 + i] = win_cols[i];
            win_cols[i]     = grid[i][2];
        end
        line_older[slot] = line_newer[slot];
        line_newer[slot] = pix;
        if (end_col)
        begin
            col_pos = '0;
            row_pos = end_row ? 12'd0 : row_pos + 12'd1;
        end
        else
            col_pos = col_pos + 10'd1;
    endfunction

    // Present one pixel beat and hold it until taken; predicts at acceptance
    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
                              input logic [7:0] r);
        if (!calm && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        blue_in  <= b;
        green_in <= g;
        red_in   <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        absorb_pixel(b, g, r);
        pixels_sent++;
    endtask

    // Resize only with the block drained and settled
    task automatic resize_frame(input logic [10:0] wid, input logic [12:0] hgt);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= 13'(wid);
        @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= hgt;
        @(posedge clk);
        cfg_we     <= 1'b0;
        width_reg  = wid;
        height_reg = hgt;
        resizes++;
    endtask

    // Output side: random back-pressure and in-order checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                edges_seen++;
                if (pending_edges.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected edge beat at row %0d col %0d",
                                 out_row, out_column);
                end
                else
                begin
                    if (pending_edges[0] !== {blue_edge, green_edge, red_edge, out_row,
                                              out_column, last_of_run, frame_done})
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: edge beat mismatch: expected b%0d g%0d r%0d ",
                                      "row %0d col %0d last %0d done %0d, got b%0d g%0d ",
                                      "r%0d row %0d col %0d last %0d done %0d"},
                                     pending_edges[0].blue, pending_edges[0].green,
                                     pending_edges[0].red, pending_edges[0].row,
                                     pending_edges[0].column, pending_edges[0].last,
                                     pending_edges[0].done, blue_edge, green_edge,
                                     red_edge, out_row, out_column, last_of_run,
                                     frame_done);
                    end
                    void'(pending_edges.pop_front());
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 38);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int          wid;
        int          hgt;
        int          count;
        int          taken;
        logic [7:0]  pb;
        logic [7:0]  pg;
        logic [7:0]  pr;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_IMAGE_WIDTH;
        cfg_data    = '0;
        in_valid    = 1'b0;
        blue_in     = '0;
        green_in    = '0;
        red_in      = '0;
        out_ready   = 1'b0;
        calm        = 1'b0;
        cycle_count = 0;
        mismatches  = 0;
        pixels_sent = 0;
        edges_seen  = 0;
        resizes     = 0;
        fresh_index = 0;
        width_reg   = 11'd640;
        height_reg  = 13'd480;
        col_pos     = '0;
        row_pos     = '0;
        for (int i = 0; i < 6; i++)
            win_cols[i] = '0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            line_older[i] = '0;
            line_newer[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; typed results are checked against the prediction
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].resize)
                resize_frame(DIRECTED[i].wid, DIRECTED[i].hgt);
            send_pixel(DIRECTED[i].blue, DIRECTED[i].green, DIRECTED[i].red);
            if (DIRECTED[i].typed && (pending_edges.size() <= fresh_index ||
                pending_edges[fresh_index] !== DIRECTED[i].want))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: directed row %0d predicts an unexpected edge beat", i);
            end
        end

        // Random frames: mostly complete small frames, some cut short.
        // The first is the widest, two rows deep, so that every column the
        // later frames can reach has been through both line buffers.
        taken = 0;
        while (taken < 140)
        begin
            if (taken == 0)
            begin
                wid = 12;
                hgt = 2;
            end
            else
            begin
                wid = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12)
                                                  : $urandom_range(1, 5);
                hgt = $urandom_range(1, 5);
            end
            resize_frame(11'(wid), 13'(hgt));
            count = (taken != 0 && $urandom_range(0, 4) == 0) ? $urandom_range(1, wid * hgt)
                                                              : wid * hgt;
            for (int k = 0; k < count; k++)
            begin
                calm = (taken >= 50 && taken < 90);
                if ($urandom_range(0, 5) == 0)
                begin
                    pb = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    pg = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    pr = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                end
                else
                begin
                    pb = 8'($urandom);
                    pg = 8'($urandom);
                    pr = 8'($urandom);
                end
                send_pixel(pb, pg, pr);
                taken++;
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Run summary: %0d pixels sent, %0d edge beats checked, %0d frame resizes",
                 pixels_sent, edges_seen, resizes);
        $display("Mismatches counted: %0d", mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
